@@ rtl/core/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and digit decode shared by the integer text parser.
// ----------------------------------------------------------------------------
package itp_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2
    } t_radix;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;

    localparam logic [4:0] DIGIT_BAD = 5'd16;

    // digit value in the given radix, DIGIT_BAD when the character is not one
    function automatic logic [4:0] digit_of(input logic [7:0] c, input t_radix mode);
        logic [4:0] d;
        d = DIGIT_BAD;
        if (mode == RX_BIN) begin
            if (c == 8'h30 || c == 8'h31) d = 5'(c - 8'h30);
        end else if (c inside {[8'h30:8'h39]}) begin
            d = 5'(c - 8'h30);
        end else if (mode == RX_HEX) begin
            if (c inside {[8'h61:8'h66]}) d = 5'(c - 8'h61 + 8'd10);
            else if (c inside {[8'h41:8'h46]}) d = 5'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

endpackage

@@ rtl/core/itp_stream_if.sv @@
// ----------------------------------------------------------------------------
// itp_stream_if
// Valid/ready channels of the integer text parser: characters in, results out.
// ----------------------------------------------------------------------------
interface itp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       char_present;
    logic       last_char;

    modport source (output valid, output char_code, output char_present,
                    output last_char, input ready);
    modport sink   (input valid, input char_code, input char_present,
                    input last_char, output ready);
endinterface

interface itp_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] parsed_value;
    logic        parse_ok;

    modport source (output valid, output parsed_value, output parse_ok, input ready);
    modport sink   (input valid, input parsed_value, input parse_ok, output ready);
endinterface

@@ rtl/core/integer_text_parser_top.sv @@
// ----------------------------------------------------------------------------
// integer_text_parser_top
// Streaming parser of signed integer text with optional 0x / 0b prefix.
// ----------------------------------------------------------------------------
// One character request per item, one result request on the item flagged
// last_char. Grammar: optional '-' or '+', optional 0x/0X (hex) or 0b/0B
// (binary) prefix right after a leading '0', else decimal, then digits.
// Throughput is one item per clock while no result waits at the output; the
// last item of a text passes the input register, then the state and result
// registers, before its result is presented.
// The figure is set by the digit step: accumulator * radix + digit is a
// shift-add on the 64-bit accumulator that sits between the input register
// and the state registers. A bad digit, a text with no characters, or
// unsigned 64-bit overflow gives parse_ok = 0 and parsed_value = 0. A text
// holding only a sign and/or prefix parses as 0 with parse_ok = 1. The
// negated accumulator is kept alongside the plain one so the sign costs no
// extra adder on the result path. All parse state returns to its reset value
// after each result. Input is stalled only while a result waits at the output.
// ----------------------------------------------------------------------------
module integer_text_parser_top
    import itp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    itp_char_if.sink     i_char,
    itp_result_if.source o_res
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_present;
    logic       r_in_last;

    // parse state
    t_phase      r_phase,   n_phase;
    t_radix      r_radix,   n_radix;
    logic        r_neg,     n_neg;
    logic [63:0] r_acc,     n_acc;
    logic [63:0] r_neg_acc, n_neg_acc;   // always equals -r_acc
    logic        r_err,     n_err;
    logic        r_seen,    n_seen;

    // result register
    logic        r_out_valid;
    logic [63:0] r_out_value, n_out_value;
    logic        r_out_ok,    n_out_ok;

    logic adv;   // second stage moves: output free or being taken

    assign adv          = !r_out_valid || o_res.ready;
    assign i_char.ready = adv || !r_in_valid;

    assign o_res.valid        = r_out_valid;
    assign o_res.parsed_value = r_out_value;
    assign o_res.parse_ok     = r_out_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char    <= i_char.char_code;
            r_in_present <= i_char.char_present;
            r_in_last    <= i_char.last_char;
        end
    end

    // digit step and grammar, one item
    always_comb begin
        logic [4:0]  d;
        logic [67:0] dec_sum;
        logic        take;
        logic        ovf;
        logic [63:0] acc_step;
        logic [63:0] neg_step;
        logic        ok;

        n_phase   = r_phase;
        n_radix   = r_radix;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_neg_acc = r_neg_acc;
        n_err     = r_err;
        n_seen    = r_seen;
        take      = 1'b0;

        if (r_in_present) begin
            n_seen = 1'b1;
            if (!r_err) begin
                case (r_phase)
                    PH_START: begin
                        if (r_in_char == CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGNED;
                        end else if (r_in_char == CH_PLUS) begin
                            n_phase = PH_SIGNED;
                        end else if (r_in_char == CH_ZERO) begin
                            n_phase = PH_ZERO;
                        end else begin
                            n_phase = PH_DIGITS;
                            take    = 1'b1;
                        end
                    end
                    PH_SIGNED: begin
                        if (r_in_char == CH_ZERO) begin
                            n_phase = PH_ZERO;
                        end else begin
                            n_phase = PH_DIGITS;
                            take    = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        n_phase = PH_DIGITS;
                        if (r_in_char == CH_LO_X || r_in_char == CH_UP_X) begin
                            n_radix = RX_HEX;
                        end else if (r_in_char == CH_LO_B || r_in_char == CH_UP_B) begin
                            n_radix = RX_BIN;
                        end else begin
                            take = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_DIGITS;
                        take    = 1'b1;
                    end
                endcase
            end
        end

        // value of the digit in the current radix; the prefix letter never
        // reaches here in the cycle it switches the radix
        d       = digit_of(r_in_char, r_radix);
        dec_sum = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {63'd0, d};
        case (r_radix)
            RX_HEX: begin
                acc_step = {r_acc[59:0], d[3:0]};
                neg_step = {r_neg_acc[59:0], 4'd0} - {60'd0, d[3:0]};
                ovf      = (r_acc[63:60] != 4'd0);
            end
            RX_BIN: begin
                acc_step = {r_acc[62:0], d[0]};
                neg_step = {r_neg_acc[62:0], 1'b0} - {63'd0, d[0]};
                ovf      = r_acc[63];
            end
            default: begin
                acc_step = dec_sum[63:0];
                neg_step = (r_neg_acc << 3) + (r_neg_acc << 1) - {59'd0, d};
                ovf      = (dec_sum[67:64] != 4'd0);
            end
        endcase

        if (take) begin
            if (d == DIGIT_BAD || ovf) begin
                n_err = 1'b1;
            end else begin
                n_acc     = acc_step;
                n_neg_acc = neg_step;
            end
        end

        ok          = n_seen && !n_err;
        n_out_ok    = ok;
        n_out_value = !ok ? 64'd0 : (n_neg ? n_neg_acc : n_acc);

        // text ends: back to the start state
        if (r_in_last) begin
            n_phase   = PH_START;
            n_radix   = RX_DEC;
            n_neg     = 1'b0;
            n_acc     = 64'd0;
            n_neg_acc = 64'd0;
            n_err     = 1'b0;
            n_seen    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_radix     <= RX_DEC;
            r_neg       <= 1'b0;
            r_acc       <= 64'd0;
            r_neg_acc   <= 64'd0;
            r_err       <= 1'b0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && r_in_last;
            if (r_in_valid) begin
                r_phase   <= n_phase;
                r_radix   <= n_radix;
                r_neg     <= n_neg;
                r_acc     <= n_acc;
                r_neg_acc <= n_neg_acc;
                r_err     <= n_err;
                r_seen    <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid && r_in_last) begin
            r_out_value <= n_out_value;
            r_out_ok    <= n_out_ok;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the negated accumulator tracks the accumulator
    a_neg_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc + r_neg_acc) == 64'd0)
        else $error("negated accumulator out of step");

    // a failed parse carries a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_value == 64'd0))
        else $error("failed parse with nonzero value");

    // state is cleared after the last item of a text
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && r_in_last) |=>
            (r_phase == PH_START && r_acc == 64'd0 && !r_err && !r_seen && !r_neg))
        else $error("state not cleared at end of text");

    // a prefix radix only exists once digits have started
    a_radix_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix != RX_DEC) |-> (r_phase == PH_DIGITS))
        else $error("prefix radix outside digit phase");

    // an empty output stage never stalls the input
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_char.ready)
        else $error("input stalled with output empty");

endmodule

@@ test/tb_integer_text_parser_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_text_parser_top
// Self-checking bench for the streaming integer text parser.
// ----------------------------------------------------------------------------
// A short table of texts covers the grammar corners: empty text, sign or
// prefix only, 64-bit extremes and overflow, late signs, stray prefix letters
// and bad bytes. A long random run of mostly well-formed texts follows, with
// broken texts and noise mixed in. Each accepted result request is compared
// with a table value or a local parse model. Both channels idle at random; the
// result side is once held off long enough to back up the input, and once the
// sender waits for every pending result to arrive.
// ----------------------------------------------------------------------------
module tb_integer_text_parser_top;
    import itp_pkg::*;

    localparam int  RANDOM_ITEMS = 1900;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam string HEX_SET    = "0123456789abcdefABCDEF";

    typedef struct packed {
        logic [63:0] value;
        logic        ok;
    } t_result;

    typedef struct {
        string       txt;
        bit          sep_end;
        bit          idle_each;
        bit          lead_on;
        logic [7:0]  lead;
        bit          typed;
        t_result     res;
    } t_text_row;

    logic i_clk;
    logic i_rst_n;

    itp_char_if   chr ();
    itp_result_if res ();

    integer_text_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (chr),
        .o_res   (res)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // parse model state
    t_phase      p_phase;
    t_radix      p_radix;
    bit          p_neg;
    logic [63:0] p_acc;
    bit          p_err;
    bit          p_seen;

    t_result     pending_results[$];
    t_text_row   text_table[$];
    int          mismatches;
    int          cycles;
    int          items_sent;
    int          sender_gap;
    int          calm_left;
    int          hold_req;
    int          hold_done;
    t_result     got_want;

    function automatic void clear_parse();
        p_phase = PH_START;
        p_radix = RX_DEC;
        p_neg   = 1'b0;
        p_acc   = '0;
        p_err   = 1'b0;
        p_seen  = 1'b0;
    endfunction

    // one input item through the model; returns 1 when it yields a result
    function automatic bit parse_step(input logic [7:0] c, input bit present,
                                      input bit last, output t_result r);
        bit          as_digit;
        logic [4:0]  dv;
        logic [68:0] wide;
        logic [68:0] radix_w;
        as_digit = 1'b0;
        r        = '0;
        if (present) begin
            p_seen = 1'b1;
            if (!p_err) begin
                case (p_phase)
                    PH_START: begin
                        if (c == CH_MINUS) begin
                            p_neg   = 1'b1;
                            p_phase = PH_SIGNED;
                        end else if (c == CH_PLUS) begin
                            p_phase = PH_SIGNED;
                        end else if (c == CH_ZERO) begin
                            p_phase = PH_ZERO;
                        end else begin
                            p_phase  = PH_DIGITS;
                            as_digit = 1'b1;
                        end
                    end
                    PH_SIGNED: begin
                        if (c == CH_ZERO) begin
                            p_phase = PH_ZERO;
                        end else begin
                            p_phase  = PH_DIGITS;
                            as_digit = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        p_phase = PH_DIGITS;
                        if (c == CH_LO_X || c == CH_UP_X) begin
                            p_radix = RX_HEX;
                        end else if (c == CH_LO_B || c == CH_UP_B) begin
                            p_radix = RX_BIN;
                        end else begin
                            as_digit = 1'b1;
                        end
                    end
                    default: begin
                        p_phase  = PH_DIGITS;
                        as_digit = 1'b1;
                    end
                endcase
            end
        end
        if (as_digit) begin
            dv = DIGIT_BAD;
            case (p_radix)
                RX_BIN: begin
                    if (c == "0" || c == "1") dv = 5'(c - "0");
                    radix_w = 69'd2;
                end
                RX_HEX: begin
                    if (c >= "0" && c <= "9")      dv = 5'(c - "0");
                    else if (c >= "a" && c <= "f") dv = 5'(c - "a" + 10);
                    else if (c >= "A" && c <= "F") dv = 5'(c - "A" + 10);
                    radix_w = 69'd16;
                end
                default: begin
                    if (c >= "0" && c <= "9") dv = 5'(c - "0");
                    radix_w = 69'd10;
                end
            endcase
            if (dv == DIGIT_BAD) begin
                p_err = 1'b1;
            end else begin
                wide = 69'(p_acc) * radix_w + 69'(dv);
                if (wide[68:64] != '0) p_err = 1'b1;
                else                   p_acc = wide[63:0];
            end
        end
        if (!last) return 1'b0;
        r.ok    = p_seen && !p_err;
        r.value = !r.ok ? 64'd0 : (p_neg ? 64'd0 - p_acc : p_acc);
        clear_parse();
        return 1'b1;
    endfunction

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // offer one request, wait for acceptance, then log what it should yield
    task automatic send_item(input logic [7:0] c, input bit present, input bit last,
                             input bit typed, input t_result typed_res);
        t_result r;
        if (sender_gap > 0) repeat (sender_gap) @(posedge i_clk);
        chr.valid        <= 1'b1;
        chr.char_code    <= c;
        chr.char_present <= present;
        chr.last_char    <= last;
        do @(posedge i_clk); while (!(chr.valid && chr.ready));
        if (parse_step(c, present, last, r)) pending_results.push_back(typed ? typed_res : r);
        if (present || last) items_sent++;
        if (calm_left > 0) begin
            calm_left--;
            sender_gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
            calm_left  = $urandom_range(20, 60);
            sender_gap = 0;
        end else begin
            sender_gap = pick_gap();
        end
        if (sender_gap > 0) chr.valid <= 1'b0;
    endtask

    task automatic send_text(input logic [7:0] chars[$], input bit sep_end,
                             input int idle_pct, input bit typed, input t_result typed_res);
        int n;
        n = chars.size();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < idle_pct)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            send_item(chars[k], 1'b1, (k == n - 1) && !sep_end, typed, typed_res);
        end
        if (sep_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, typed, typed_res);
    endtask

    // make sure valid is low before a pause
    task automatic idle_sender();
        if (sender_gap == 0) chr.valid <= 1'b0;
        @(posedge i_clk);
        sender_gap = 0;
    endtask

    function automatic void add_row(input string txt, input bit sep_end, input bit idle_each,
                                    input bit lead_on, input logic [7:0] lead,
                                    input bit typed, input logic [63:0] value, input bit ok);
        t_text_row row;
        row.txt       = txt;
        row.sep_end   = sep_end;
        row.idle_each = idle_each;
        row.lead_on   = lead_on;
        row.lead      = lead;
        row.typed     = typed;
        row.res.value = value;
        row.res.ok    = ok;
        text_table.push_back(row);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("result %h/%b with nothing pending",
                                 res.parsed_value, res.parse_ok));
            end else begin
                got_want = pending_results.pop_front();
                if (res.parsed_value !== got_want.value)
                    report($sformatf("parsed_value %h, want %h",
                                     res.parsed_value, got_want.value));
                if (res.parse_ok !== got_want.ok)
                    report($sformatf("parse_ok %b, want %b", res.parse_ok, got_want.ok));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random back-pressure, calm stretches, one long hold on request
    initial begin
        res.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req != hold_done) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else if ($urandom_range(0, 99) < 10) begin
                res.ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                int gap;
                gap = pick_gap();
                if (gap > 0) begin
                    res.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [7:0] q[$];
        bit         sep;
        bit         long_run;
        bit         held_once;
        bit         drained_once;
        int         kind;
        int         radix_sel;
        int         n;
        logic [7:0] ch;

        mismatches   = 0;
        cycles       = 0;
        items_sent   = 0;
        sender_gap   = 0;
        calm_left    = 0;
        hold_req     = 0;
        hold_done    = 0;
        held_once    = 1'b0;
        drained_once = 1'b0;
        clear_parse();

        i_rst_n          <= 1'b0;
        chr.valid        <= 1'b0;
        chr.char_code    <= '0;
        chr.char_present <= 1'b0;
        chr.last_char    <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        //      text                    sep idl lead        typed value                 ok
        add_row("",                     1, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("0",                    0, 0, 0, 8'h00, 1, 64'd0,                  1);
        add_row("-",                    0, 0, 0, 8'h00, 1, 64'd0,                  1);
        add_row("+",                    1, 0, 0, 8'h00, 1, 64'd0,                  1);
        add_row("0x",                   0, 0, 0, 8'h00, 1, 64'd0,                  1);
        add_row("-0b",                  1, 0, 0, 8'h00, 1, 64'd0,                  1);
        add_row("18446744073709551615", 0, 0, 0, 8'h00, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        add_row("18446744073709551616", 0, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("0xFFFFFFFFFFFFFFFF",   0, 0, 0, 8'h00, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        add_row("0x10000000000000000",  0, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("-9223372036854775808", 0, 0, 0, 8'h00, 1, 64'h8000_0000_0000_0000, 1);
        add_row("-1",                   0, 0, 0, 8'h00, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        add_row("12-3",                 0, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("-+5",                  0, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("1x",                   0, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("00x1",                 0, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("0b2",                  0, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("0x1g",                 1, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("1z234",                0, 0, 0, 8'h00, 1, 64'd0,                  0);
        add_row("5",                    0, 0, 1, 8'h00, 1, 64'd0,                  0);
        add_row("",                     0, 0, 1, 8'hFF, 1, 64'd0,                  0);
        add_row("0B1011",               0, 0, 0, 8'h00, 0, 64'd0,                  0);
        add_row("0XaFbB",               0, 0, 0, 8'h00, 0, 64'd0,                  0);
        add_row("+12345",               1, 1, 0, 8'h00, 0, 64'd0,                  0);
        add_row("-0x7fffFFFFffffffff",  0, 0, 0, 8'h00, 0, 64'd0,                  0);

        foreach (text_table[i]) begin
            q.delete();
            if (text_table[i].lead_on) q.push_back(text_table[i].lead);
            for (int k = 0; k < text_table[i].txt.len(); k++) q.push_back(text_table[i].txt[k]);
            send_text(q, text_table[i].sep_end, text_table[i].idle_each ? 100 : 0,
                      text_table[i].typed, text_table[i].res);
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!held_once && items_sent >= 600) begin
                hold_req++;
                held_once = 1'b1;
            end
            if (!drained_once && items_sent >= 1200) begin
                idle_sender();
                while (pending_results.size() != 0) @(posedge i_clk);
                drained_once = 1'b1;
            end

            q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 95) begin
                // optionally signed and prefixed digit run with random content
                case ($urandom_range(0, 3))
                    0:       q.push_back(CH_MINUS);
                    1:       q.push_back(CH_PLUS);
                    default: ;
                endcase
                radix_sel = $urandom_range(0, 2);
                if (radix_sel == 1) begin
                    q.push_back(CH_ZERO);
                    q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                end else if (radix_sel == 2) begin
                    q.push_back(CH_ZERO);
                    q.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
                end
                long_run = ($urandom_range(0, 99) < 10);
                if (!long_run)          n = $urandom_range(0, 8);
                else if (radix_sel == 0) n = $urandom_range(18, 21);
                else if (radix_sel == 1) n = $urandom_range(15, 17);
                else                    n = $urandom_range(62, 65);
                for (int k = 0; k < n; k++) begin
                    if (long_run && $urandom_range(0, 1)) begin
                        ch = (radix_sel == 0) ? "9" : (radix_sel == 1) ? "f" : "1";
                    end else begin
                        case (radix_sel)
                            0:       ch = 8'("0" + $urandom_range(0, 9));
                            1:       ch = HEX_SET[$urandom_range(0, HEX_SET.len() - 1)];
                            default: ch = 8'("0" + $urandom_range(0, 1));
                        endcase
                    end
                    q.push_back(ch);
                end
                // broken text: one stray character somewhere
                if (kind >= 80) begin
                    case ($urandom_range(0, 7))
                        0:       ch = CH_MINUS;
                        1:       ch = CH_PLUS;
                        2:       ch = CH_LO_X;
                        3:       ch = CH_UP_X;
                        4:       ch = CH_LO_B;
                        5:       ch = CH_UP_B;
                        6:       ch = "g";
                        default: ch = 8'($urandom_range(0, 255));
                    endcase
                    q.insert($urandom_range(0, q.size()), ch);
                end
            end else begin
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) q.push_back(8'($urandom_range(0, 255)));
            end
            sep = (q.size() == 0) || ($urandom_range(0, 99) < 25);
            send_text(q, sep, 5, 1'b0, '0);
        end

        idle_sender();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/itp_pkg.sv
rtl/core/itp_stream_if.sv
rtl/core/integer_text_parser_top.sv
test/tb_integer_text_parser_top.sv
